// ===== hw/rtl/eil4hp_pkg.sv =====
package eil4hp_pkg;

   localparam int REQ_TDATA_W = 8;
   localparam int RSP_TDATA_W = 56;

   localparam int COUNT_W = 7;
   localparam logic [COUNT_W-1:0] COUNT_MAX = 7'd127;

   // Byte offsets within the frame, counted from zero.
   localparam logic [COUNT_W-1:0] OFS_ETYPE_HI = 7'd12;
   localparam logic [COUNT_W-1:0] OFS_ETYPE_LO = 7'd13;
   localparam logic [COUNT_W-1:0] OFS_IHL      = 7'd14;
   localparam logic [COUNT_W-1:0] OFS_PROTO    = 7'd23;
   localparam logic [COUNT_W-1:0] OFS_SRC_FIRST = 7'd26;
   localparam logic [COUNT_W-1:0] OFS_SRC_LAST  = 7'd29;
   localparam logic [COUNT_W-1:0] OFS_PORT_BASE = 7'd16;

   // Length thresholds, compared against an 8-bit frame length; IHL_MIN bounds the 4-bit IHL.
   localparam logic [7:0] ETH_HDR_LEN    = 8'd14;
   localparam logic [7:0] IPV4_MIN_FRAME = 8'd34;
   localparam logic [7:0] TCP_HDR_LEN    = 8'd20;
   localparam logic [7:0] UDP_HDR_LEN    = 8'd8;
   localparam logic [3:0] IHL_MIN        = 4'd5;

   localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
   localparam logic [7:0]  PROTO_TCP      = 8'd6;
   localparam logic [7:0]  PROTO_UDP      = 8'd17;

   typedef enum logic [1:0] {
      TRANSPORT_OTHER = 2'd0,
      TRANSPORT_TCP   = 2'd1,
      TRANSPORT_UDP   = 2'd2
   } transport_type;

   localparam logic VERDICT_PASS = 1'b0;
   localparam logic VERDICT_DROP = 1'b1;

   // Result word layout, highest bit first.
   typedef struct packed {
      logic [4:0]    pad;
      logic [15:0]   destination_port;
      logic [31:0]   source_address;
      transport_type transport;
      logic          verdict;
   } rsp_word_type;

endpackage

// ===== hw/rtl/ethernet_ipv4_l4_header_parser.sv =====
// Channel  Dir  Signals                        Word contents (low bit first)
// req      in   req_tvalid/tready/tdata/tlast  tdata[7:0] data_byte; tlast last_byte
// rsp      out  rsp_tvalid/tready/tdata        tdata[0] verdict, [2:1] transport,
//                                              [34:3] source_address,
//                                              [50:35] destination_port, [55:51] zero
// One frame byte is accepted per cycle unless a last byte waits on a stalled
// result. A byte is first held in the input register; the verdict for the last
// byte of a frame is loaded into the result register as that byte moves on.
// Reset is synchronous and clears the byte counter, the captured fields and
// both valid flags. A stalled result only holds up the input register when it
// carries another last byte; ordinary bytes keep flowing underneath it.
module ethernet_ipv4_l4_header_parser (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [eil4hp_pkg::REQ_TDATA_W-1:0]  req_tdata,   // [7:0] data_byte
   input  logic                                req_tlast,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [eil4hp_pkg::RSP_TDATA_W-1:0]  rsp_tdata    // verdict, transport,
                                                            // source_address,
                                                            // destination_port, pad
);
   import eil4hp_pkg::*;

   // Input register.
   logic                   s1_valid_ff, s1_valid_in;
   logic [REQ_TDATA_W-1:0] s1_data_ff;
   logic                   s1_last_ff;

   // Parser state.
   logic [COUNT_W-1:0] byte_count_ff, byte_count_in;
   logic [15:0]        ether_type_ff, ether_type_in;
   logic [3:0]         header_words_ff, header_words_in;
   logic [7:0]         ip_protocol_ff, ip_protocol_in;
   logic [31:0]        src_ip_ff, src_ip_in;
   logic [15:0]        dst_port_ff, dst_port_in;

   // Result register.
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_word_type rsp_word_ff, rsp_word_in;

   logic               advance;
   logic               load_rsp;
   logic               req_accept;
   logic [COUNT_W-1:0] idx;
   logic [COUNT_W-1:0] port_at;
   logic [7:0]         frame_len;
   logic [7:0]         ip_hdr_end;
   logic [7:0]         need_len;

   // The input register moves on unless it holds a last byte while the
   // result register is full and stalled.
   assign advance    = !s1_valid_ff || !s1_last_ff || !rsp_valid_ff || rsp_tready;
   assign load_rsp   = s1_valid_ff && s1_last_ff && advance;
   assign req_tready = advance;
   assign req_accept = req_tvalid && req_tready;

   assign idx     = byte_count_ff;
   assign port_at = OFS_PORT_BASE + {1'b0, header_words_ff, 2'b00};

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      ether_type_in   = ether_type_ff;
      header_words_in = header_words_ff;
      ip_protocol_in  = ip_protocol_ff;
      src_ip_in       = src_ip_ff;
      dst_port_in     = dst_port_ff;

      if (idx == OFS_ETYPE_HI || idx == OFS_ETYPE_LO) begin
         ether_type_in = {ether_type_ff[7:0], s1_data_ff};
      end
      if (idx == OFS_IHL) begin
         header_words_in = s1_data_ff[3:0];
      end
      if (idx == OFS_PROTO) begin
         ip_protocol_in = s1_data_ff;
      end
      if (idx >= OFS_SRC_FIRST && idx <= OFS_SRC_LAST) begin
         src_ip_in = {src_ip_ff[23:0], s1_data_ff};
      end
      // The port offset follows the IHL captured on an earlier byte.
      if (idx > OFS_IHL && (idx == port_at || idx == port_at + 7'd1)) begin
         dst_port_in = {dst_port_ff[7:0], s1_data_ff};
      end

      byte_count_in = (idx < COUNT_MAX) ? idx + 7'd1 : COUNT_MAX;
   end

   always_comb begin
      frame_len  = {1'b0, idx} + 8'd1;
      ip_hdr_end = ETH_HDR_LEN + {2'b00, header_words_in, 2'b00};
      case (ip_protocol_in)
         PROTO_TCP: need_len = ip_hdr_end + TCP_HDR_LEN;
         default:   need_len = ip_hdr_end + UDP_HDR_LEN;
      endcase

      rsp_word_in                  = '0;
      rsp_word_in.verdict          = VERDICT_PASS;
      rsp_word_in.transport        = TRANSPORT_OTHER;
      if (frame_len < ETH_HDR_LEN) begin
         rsp_word_in.verdict = VERDICT_DROP;
      end else if (ether_type_in != ETHERTYPE_IPV4) begin
         rsp_word_in.verdict = VERDICT_PASS;
      end else if (frame_len < IPV4_MIN_FRAME || header_words_in < IHL_MIN) begin
         rsp_word_in.verdict = VERDICT_DROP;
      end else if (ip_protocol_in == PROTO_TCP || ip_protocol_in == PROTO_UDP) begin
         rsp_word_in.transport = (ip_protocol_in == PROTO_TCP) ? TRANSPORT_TCP
                                                               : TRANSPORT_UDP;
         if (frame_len < need_len) begin
            rsp_word_in.verdict = VERDICT_DROP;
         end else begin
            rsp_word_in.source_address   = src_ip_in;
            rsp_word_in.destination_port = dst_port_in;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         byte_count_ff   <= '0;
         ether_type_ff   <= '0;
         header_words_ff <= '0;
         ip_protocol_ff  <= '0;
         src_ip_ff       <= '0;
         dst_port_ff     <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (s1_valid_ff && advance) begin
            if (s1_last_ff) begin
               // End of frame: all captured state goes back to its reset values.
               byte_count_ff   <= '0;
               ether_type_ff   <= '0;
               header_words_ff <= '0;
               ip_protocol_ff  <= '0;
               src_ip_ff       <= '0;
               dst_port_ff     <= '0;
            end else begin
               byte_count_ff   <= byte_count_in;
               ether_type_ff   <= ether_type_in;
               header_words_ff <= header_words_in;
               ip_protocol_ff  <= ip_protocol_in;
               src_ip_ff       <= src_ip_in;
               dst_port_ff     <= dst_port_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_data_ff <= req_tdata;
         s1_last_ff <= req_tlast;
      end
      if (load_rsp) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_word_ff;

   // A dropped frame never reports an address or a port.
   a_drop_no_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_word_ff.verdict == VERDICT_DROP |->
         rsp_word_ff.source_address == '0 && rsp_word_ff.destination_port == '0)
      else $error("dropped frame carries address or port");

   // Address and port are only reported for TCP or UDP.
   a_other_no_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_word_ff.transport == TRANSPORT_OTHER |->
         rsp_word_ff.source_address == '0 && rsp_word_ff.destination_port == '0)
      else $error("non-transport frame carries address or port");

   // The parser state is cleared after the last byte of a frame.
   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      load_rsp |=> byte_count_ff == '0 && header_words_ff == '0 && ether_type_ff == '0)
      else $error("parser state not cleared after frame end");

   // A last byte held in the input register is never lost behind a stall.
   a_last_held: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s1_last_ff && !advance |=> s1_valid_ff && s1_last_ff)
      else $error("stalled last byte left the input register");

endmodule
